// ===== rtl/msvf_pkg.sv =====
// ----------------------------------------------------------------------------
// msvf_pkg
// Shared widths, codes, command/status types and saturation helpers for the
// multimode state variable filter.
// ----------------------------------------------------------------------------
package msvf_pkg;

  // Channel payload widths.
  localparam int SAMPLE_BITS  = 24;
  localparam int NUM_CHANNELS = 2;
  localparam int CH_BITS      = 1;

  // Coefficients are Q8.24.
  localparam int COEF_W = 32;
  localparam int FRAC   = 24;

  // Integrator and response word.
  localparam int ST_W = 40;

  // Multiplier: 40-bit magnitude times 34-bit magnitude, in two halves.
  localparam int MAG_W  = ST_W;
  localparam int MB_W   = 34;
  localparam int HALF   = MAG_W / 2;
  localparam int PP_W   = HALF + MB_W;
  localparam int P_W    = MAG_W + MB_W;
  localparam int MRES_W = P_W + 1 - FRAC;

  // Adder width wide enough for three product-sized terms.
  localparam int SUM_W = MRES_W + 3;

  // Divider: loop denominator and quotient.
  localparam int DEN_W  = 43;
  localparam int Q_W    = ST_W;
  localparam int DIV_HI = MAG_W + FRAC - Q_W;
  localparam int CNT_W  = $clog2(Q_W);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_ENABLE = 3'd0;
  localparam reg_idx_t REG_TYPE   = 3'd1;
  localparam reg_idx_t REG_G      = 3'd2;
  localparam reg_idx_t REG_R      = 3'd3;
  localparam reg_idx_t REG_K      = 3'd4;

  // Filter responses.
  typedef logic [2:0] ftype_t;
  localparam ftype_t FT_LOW     = 3'd0;
  localparam ftype_t FT_BAND    = 3'd1;
  localparam ftype_t FT_HIGH    = 3'd2;
  localparam ftype_t FT_UBAND   = 3'd3;
  localparam ftype_t FT_SHELF   = 3'd4;
  localparam ftype_t FT_NOTCH   = 3'd5;
  localparam ftype_t FT_ALLPASS = 3'd6;
  localparam ftype_t FT_PEAK    = 3'd7;

  // Multiply operations issued to the shared multiplier.
  typedef logic [2:0] op_t;
  localparam op_t OP_RG    = 3'd0;  // R * g, first denominator term
  localparam op_t OP_GG    = 3'd1;  // g * g, second denominator term
  localparam op_t OP_Z1    = 3'd2;  // z1 * (2R + g)
  localparam op_t OP_HG    = 3'd3;  // HP * g
  localparam op_t OP_BG    = 3'd4;  // BP * g
  localparam op_t OP_UBP   = 3'd5;  // BP * 2R
  localparam op_t OP_SHELF = 3'd6;  // UBP * K
  localparam op_t OP_AP    = 3'd7;  // BP * 4R

  // Response picked when the integrators are updated.
  typedef logic [1:0] ysel_t;
  localparam ysel_t Y_LP   = 2'd0;
  localparam ysel_t Y_BP   = 2'd1;
  localparam ysel_t Y_HP   = 2'd2;
  localparam ysel_t Y_PEAK = 2'd3;

  typedef struct packed {
    logic  load;
    logic  mul_start;
    logic  mul_post;
    logic  div_start;
    logic  div_post;
    logic  upd;
    logic  notch;
    logic  out_load;
    op_t   op;
    ysel_t ysel;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic ch_ok;
  } st_t;

  function automatic logic signed [SUM_W-1:0] sx_st(input logic signed [ST_W-1:0] v);
    return {{(SUM_W-ST_W){v[ST_W-1]}}, v};
  endfunction

  function automatic logic signed [SUM_W-1:0] sx_mr(input logic signed [MRES_W-1:0] v);
    return {{(SUM_W-MRES_W){v[MRES_W-1]}}, v};
  endfunction

  function automatic logic [MAG_W-1:0] abs_st(input logic signed [ST_W-1:0] v);
    return v[ST_W-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

  // Clamp a wide sum to the integrator word.
  function automatic logic signed [ST_W-1:0] sat_st(input logic signed [SUM_W-1:0] v);
    if ((&v[SUM_W-1:ST_W-1]) || !(|v[SUM_W-1:ST_W-1])) begin
      return v[ST_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(ST_W-1){1'b0}}};
    end else begin
      return {1'b0, {(ST_W-1){1'b1}}};
    end
  endfunction

  // Clamp an integrator word to the output sample.
  function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(
    input logic signed [ST_W-1:0] v
  );
    if ((&v[ST_W-1:SAMPLE_BITS-1]) || !(|v[ST_W-1:SAMPLE_BITS-1])) begin
      return v[SAMPLE_BITS-1:0];
    end else if (v[ST_W-1]) begin
      return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

endpackage

// ===== rtl/msvf_if.sv =====
// ----------------------------------------------------------------------------
// msvf_if
// Valid/ready channels of the filter: sample input, result output and the
// configuration write port.
// ----------------------------------------------------------------------------
interface msvf_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [msvf_pkg::SAMPLE_BITS-1:0] sample_in;
  logic [msvf_pkg::CH_BITS-1:0]            channel;
  logic                                    block_end;

  modport source (output valid, sample_in, channel, block_end, input ready);
  modport sink   (input valid, sample_in, channel, block_end, output ready);
endinterface

interface msvf_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [msvf_pkg::SAMPLE_BITS-1:0] sample_out;
  logic [msvf_pkg::CH_BITS-1:0]            channel_out;
  logic                                    block_end_out;

  modport source (output valid, sample_out, channel_out, block_end_out, input ready);
  modport sink   (input valid, sample_out, channel_out, block_end_out, output ready);
endinterface

interface msvf_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [msvf_pkg::CFG_IDX_W-1:0]    index;
  logic [msvf_pkg::COEF_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/msvf_mul.sv =====
// ----------------------------------------------------------------------------
// msvf_mul
// Shared sign-magnitude multiplier. Builds the full product from two
// 20 x 34 partial products and returns it raw and as a floored Q8.24 result.
// ----------------------------------------------------------------------------
module msvf_mul (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [msvf_pkg::MAG_W-1:0]          a_mag,
  input  logic [msvf_pkg::MB_W-1:0]           b_mag,
  input  logic                                neg,
  output logic                                done,
  output logic [msvf_pkg::P_W-1:0]            prod,
  output logic signed [msvf_pkg::MRES_W-1:0]  res
);

  logic                               busy_r;
  logic [1:0]                         ph_r;
  logic                               done_r;
  logic [msvf_pkg::MAG_W-1:0]         a_r;
  logic [msvf_pkg::MB_W-1:0]          b_r;
  logic                               neg_r;
  logic [msvf_pkg::PP_W-1:0]          pp_r;
  logic [msvf_pkg::P_W-1:0]           acc_r;
  logic signed [msvf_pkg::MRES_W-1:0] res_r;

  logic [msvf_pkg::HALF-1:0]          a_half;
  logic [msvf_pkg::PP_W-1:0]          pp_nxt;
  logic signed [msvf_pkg::P_W:0]      sp;

  assign a_half = (ph_r == 2'd0) ? a_r[msvf_pkg::HALF-1:0]
                                 : a_r[msvf_pkg::MAG_W-1:msvf_pkg::HALF];
  assign pp_nxt = msvf_pkg::PP_W'(a_half) * msvf_pkg::PP_W'(b_r);

  // Floor of a negative quotient is the arithmetic shift of the negated product.
  assign sp = neg_r ? -$signed({1'b0, acc_r}) : $signed({1'b0, acc_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= 2'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        ph_r   <= 2'd0;
      end else if (busy_r) begin
        ph_r <= ph_r + 2'd1;
        if (ph_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a_mag;
      b_r   <= b_mag;
      neg_r <= neg;
    end else if (busy_r) begin
      case (ph_r)
        2'd0: pp_r <= pp_nxt;
        2'd1: begin
          acc_r <= msvf_pkg::P_W'(pp_r);
          pp_r  <= pp_nxt;
        end
        2'd2: acc_r <= acc_r + {pp_r, {msvf_pkg::HALF{1'b0}}};
        default: res_r <= sp[msvf_pkg::P_W:msvf_pkg::FRAC];
      endcase
    end
  end

  assign done = done_r;
  assign prod = acc_r;
  assign res  = res_r;

endmodule

// ===== rtl/msvf_div.sv =====
// ----------------------------------------------------------------------------
// msvf_div
// Restoring divider for the highpass term: floor(mag * 2^24 / den), one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module msvf_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [msvf_pkg::MAG_W-1:0]   mag,
  input  logic [msvf_pkg::DEN_W-1:0]   den,
  output logic                         done,
  output logic [msvf_pkg::Q_W-1:0]     quo
);

  logic                         busy_r;
  logic                         done_r;
  logic [msvf_pkg::CNT_W-1:0]   cnt_r;
  logic [msvf_pkg::DEN_W-1:0]   rem_r;
  logic [msvf_pkg::Q_W-1:0]     dvd_r;
  logic [msvf_pkg::Q_W-1:0]     q_r;

  logic [msvf_pkg::DEN_W:0]     trial;
  logic [msvf_pkg::DEN_W:0]     diff;
  logic                         fits;

  assign trial = {rem_r, dvd_r[msvf_pkg::Q_W-1]};
  assign diff  = trial - {1'b0, den};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // The upper part of the shifted dividend is below den, so only the low
  // Q_W bits produce quotient bits.
  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= msvf_pkg::CNT_W'(msvf_pkg::Q_W - 1);
      rem_r <= {{(msvf_pkg::DEN_W-msvf_pkg::DIV_HI){1'b0}},
                mag[msvf_pkg::MAG_W-1 -: msvf_pkg::DIV_HI]};
      dvd_r <= {mag[msvf_pkg::MAG_W-msvf_pkg::DIV_HI-1:0], {msvf_pkg::FRAC{1'b0}}};
    end else if (busy_r) begin
      cnt_r <= cnt_r - msvf_pkg::CNT_W'(1);
      rem_r <= fits ? diff[msvf_pkg::DEN_W-1:0] : trial[msvf_pkg::DEN_W-1:0];
      dvd_r <= {dvd_r[msvf_pkg::Q_W-2:0], 1'b0};
      q_r   <= {q_r[msvf_pkg::Q_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// ===== rtl/msvf_dp.sv =====
// ----------------------------------------------------------------------------
// msvf_dp
// Filter datapath: integrator state per channel, working registers, the
// shared multiplier and divider, response forming and the result register.
// ----------------------------------------------------------------------------
module msvf_dp (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic signed [msvf_pkg::SAMPLE_BITS-1:0]  in_sample,
  input  logic [msvf_pkg::CH_BITS-1:0]             in_channel,
  input  logic                                     in_block_end,
  input  logic [msvf_pkg::COEF_W-1:0]              g_coeff,
  input  logic [msvf_pkg::COEF_W-1:0]              r_coeff,
  input  logic signed [msvf_pkg::COEF_W-1:0]       k_coeff,
  input  msvf_pkg::cmd_t                           cmd,
  output msvf_pkg::st_t                            st,
  output logic signed [msvf_pkg::SAMPLE_BITS-1:0]  out_sample,
  output logic [msvf_pkg::CH_BITS-1:0]             out_channel,
  output logic                                     out_block_end
);

  logic signed [msvf_pkg::ST_W-1:0]   z1_mem_r [msvf_pkg::NUM_CHANNELS];
  logic signed [msvf_pkg::ST_W-1:0]   z2_mem_r [msvf_pkg::NUM_CHANNELS];

  logic signed [msvf_pkg::ST_W-1:0]   x_r, z1_r, z2_r, num_r, hp_r, bp_r, lp_r, ubp_r, y_r;
  logic signed [msvf_pkg::MRES_W-1:0] hg_r, bg_r;
  logic [msvf_pkg::DEN_W-1:0]         den_r;
  logic [msvf_pkg::CH_BITS-1:0]       ch_r;
  logic                               be_r;
  logic signed [msvf_pkg::SAMPLE_BITS-1:0] out_sample_r;
  logic [msvf_pkg::CH_BITS-1:0]       out_ch_r;
  logic                               out_be_r;

  logic [msvf_pkg::MAG_W-1:0]         mul_a;
  logic [msvf_pkg::MB_W-1:0]          mul_b;
  logic                               mul_neg;
  logic                               mul_done;
  logic [msvf_pkg::P_W-1:0]           mul_prod;
  logic signed [msvf_pkg::MRES_W-1:0] mul_res;
  logic                               div_done;
  logic [msvf_pkg::Q_W-1:0]           div_q;

  logic [msvf_pkg::COEF_W-1:0]        k_mag;
  logic signed [msvf_pkg::ST_W-1:0]   x_in;
  logic signed [msvf_pkg::SUM_W-1:0]  prod_s, hp_q;
  logic signed [msvf_pkg::SUM_W-1:0]  num_sum, hp_sum, peak_sum, notch_sum;
  logic signed [msvf_pkg::SUM_W-1:0]  z1_sum, z2_sum;

  assign x_in  = {{(msvf_pkg::ST_W-msvf_pkg::SAMPLE_BITS){in_sample[msvf_pkg::SAMPLE_BITS-1]}},
                  in_sample};
  assign k_mag = k_coeff[msvf_pkg::COEF_W-1] ? msvf_pkg::COEF_W'(-k_coeff)
                                             : msvf_pkg::COEF_W'(k_coeff);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    unique case (cmd.op)
      msvf_pkg::OP_RG: begin
        mul_a = msvf_pkg::MAG_W'(r_coeff);
        mul_b = msvf_pkg::MB_W'(g_coeff);
      end
      msvf_pkg::OP_GG: begin
        mul_a = msvf_pkg::MAG_W'(g_coeff);
        mul_b = msvf_pkg::MB_W'(g_coeff);
      end
      msvf_pkg::OP_Z1: begin
        mul_a   = msvf_pkg::abs_st(z1_r);
        mul_b   = {1'b0, r_coeff, 1'b0} + {2'b00, g_coeff};
        mul_neg = z1_r[msvf_pkg::ST_W-1];
      end
      msvf_pkg::OP_HG: begin
        mul_a   = msvf_pkg::abs_st(hp_r);
        mul_b   = msvf_pkg::MB_W'(g_coeff);
        mul_neg = hp_r[msvf_pkg::ST_W-1];
      end
      msvf_pkg::OP_BG: begin
        mul_a   = msvf_pkg::abs_st(bp_r);
        mul_b   = msvf_pkg::MB_W'(g_coeff);
        mul_neg = bp_r[msvf_pkg::ST_W-1];
      end
      msvf_pkg::OP_UBP: begin
        mul_a   = msvf_pkg::abs_st(bp_r);
        mul_b   = {1'b0, r_coeff, 1'b0};
        mul_neg = bp_r[msvf_pkg::ST_W-1];
      end
      msvf_pkg::OP_SHELF: begin
        mul_a   = msvf_pkg::abs_st(ubp_r);
        mul_b   = msvf_pkg::MB_W'(k_mag);
        mul_neg = ubp_r[msvf_pkg::ST_W-1] ^ k_coeff[msvf_pkg::COEF_W-1];
      end
      msvf_pkg::OP_AP: begin
        mul_a   = msvf_pkg::abs_st(bp_r);
        mul_b   = {r_coeff, 2'b00};
        mul_neg = bp_r[msvf_pkg::ST_W-1];
      end
    endcase
  end

  msvf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a_mag (mul_a),
    .b_mag (mul_b),
    .neg   (mul_neg),
    .done  (mul_done),
    .prod  (mul_prod),
    .res   (mul_res)
  );

  msvf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .mag   (msvf_pkg::abs_st(num_r)),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_q)
  );

  assign prod_s    = msvf_pkg::sx_mr(mul_res);
  assign num_sum   = msvf_pkg::sx_st(x_r) - prod_s - msvf_pkg::sx_st(z2_r);
  assign hp_q      = {{(msvf_pkg::SUM_W-msvf_pkg::Q_W){1'b0}}, div_q};
  assign hp_sum    = num_r[msvf_pkg::ST_W-1] ? -hp_q : hp_q;
  assign peak_sum  = msvf_pkg::sx_st(lp_r) - msvf_pkg::sx_st(hp_r);
  assign notch_sum = msvf_pkg::sx_st(x_r) - msvf_pkg::sx_st(ubp_r);
  assign z1_sum    = msvf_pkg::sx_mr(hg_r) + msvf_pkg::sx_st(bp_r);
  assign z2_sum    = msvf_pkg::sx_mr(bg_r) + msvf_pkg::sx_st(lp_r);

  // Integrator state, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < msvf_pkg::NUM_CHANNELS; i++) begin
        z1_mem_r[i] <= '0;
        z2_mem_r[i] <= '0;
      end
    end else if (cmd.upd) begin
      z1_mem_r[ch_r] <= msvf_pkg::sat_st(z1_sum);
      z2_mem_r[ch_r] <= msvf_pkg::sat_st(z2_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r  <= x_in;
      y_r  <= x_in;
      ch_r <= in_channel;
      be_r <= in_block_end;
      z1_r <= z1_mem_r[in_channel];
      z2_r <= z2_mem_r[in_channel];
    end
    if (cmd.mul_post) begin
      case (cmd.op)
        msvf_pkg::OP_RG: begin
          den_r <= {{(msvf_pkg::DEN_W-msvf_pkg::FRAC-1){1'b0}}, 1'b1, {msvf_pkg::FRAC{1'b0}}}
                   + mul_prod[msvf_pkg::FRAC-1 +: msvf_pkg::DEN_W];
        end
        msvf_pkg::OP_GG:    den_r <= den_r + mul_prod[msvf_pkg::FRAC +: msvf_pkg::DEN_W];
        msvf_pkg::OP_Z1:    num_r <= msvf_pkg::sat_st(num_sum);
        msvf_pkg::OP_HG: begin
          hg_r <= mul_res;
          bp_r <= msvf_pkg::sat_st(prod_s + msvf_pkg::sx_st(z1_r));
        end
        msvf_pkg::OP_BG: begin
          bg_r <= mul_res;
          lp_r <= msvf_pkg::sat_st(prod_s + msvf_pkg::sx_st(z2_r));
        end
        msvf_pkg::OP_UBP: begin
          ubp_r <= msvf_pkg::sat_st(prod_s);
          y_r   <= msvf_pkg::sat_st(prod_s);
        end
        msvf_pkg::OP_SHELF: y_r <= msvf_pkg::sat_st(msvf_pkg::sx_st(x_r) + prod_s);
        default:            y_r <= msvf_pkg::sat_st(msvf_pkg::sx_st(x_r) - prod_s);
      endcase
    end
    if (cmd.div_post) begin
      hp_r <= msvf_pkg::sat_st(hp_sum);
    end
    if (cmd.upd) begin
      case (cmd.ysel)
        msvf_pkg::Y_LP: y_r <= lp_r;
        msvf_pkg::Y_BP: y_r <= bp_r;
        msvf_pkg::Y_HP: y_r <= hp_r;
        default:        y_r <= msvf_pkg::sat_st(peak_sum);
      endcase
    end
    if (cmd.notch) begin
      y_r <= msvf_pkg::sat_st(notch_sum);
    end
    if (cmd.out_load) begin
      out_sample_r <= msvf_pkg::sat_smp(y_r);
      out_ch_r     <= ch_r;
      out_be_r     <= be_r;
    end
  end

  assign st.mul_done = mul_done;
  assign st.div_done = div_done;
  assign st.ch_ok    = int'(in_channel) < msvf_pkg::NUM_CHANNELS;

  assign out_sample    = out_sample_r;
  assign out_channel   = out_ch_r;
  assign out_block_end = out_be_r;

endmodule

// ===== rtl/msvf_ctrl.sv =====
// ----------------------------------------------------------------------------
// msvf_ctrl
// Sequencer for the filter: steps one sample through the multiply, divide
// and update operations and owns the input and result handshakes.
// ----------------------------------------------------------------------------
module msvf_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  input  logic                    enable,
  input  msvf_pkg::ftype_t        filter_type,
  input  msvf_pkg::st_t           st,
  output msvf_pkg::cmd_t          cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MSTART = 3'd1;
  localparam logic [2:0] S_MWAIT  = 3'd2;
  localparam logic [2:0] S_DSTART = 3'd3;
  localparam logic [2:0] S_DWAIT  = 3'd4;
  localparam logic [2:0] S_UPD    = 3'd5;
  localparam logic [2:0] S_NOTCH  = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]      state_r, state_nxt;
  msvf_pkg::op_t   op_r, op_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    cmd.op    = op_r;
    state_nxt = state_r;
    op_nxt    = op_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (enable && st.ch_ok) begin
            op_nxt    = msvf_pkg::OP_RG;
            state_nxt = S_MSTART;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_MSTART: begin
        cmd.mul_start = 1'b1;
        state_nxt     = S_MWAIT;
      end
      S_MWAIT: begin
        if (st.mul_done) begin
          cmd.mul_post = 1'b1;
          unique case (op_r)
            msvf_pkg::OP_RG: begin
              op_nxt    = msvf_pkg::OP_GG;
              state_nxt = S_MSTART;
            end
            msvf_pkg::OP_GG: begin
              op_nxt    = msvf_pkg::OP_Z1;
              state_nxt = S_MSTART;
            end
            msvf_pkg::OP_Z1: state_nxt = S_DSTART;
            msvf_pkg::OP_HG: begin
              op_nxt    = msvf_pkg::OP_BG;
              state_nxt = S_MSTART;
            end
            msvf_pkg::OP_BG: state_nxt = S_UPD;
            msvf_pkg::OP_UBP: begin
              if (filter_type == msvf_pkg::FT_SHELF) begin
                op_nxt    = msvf_pkg::OP_SHELF;
                state_nxt = S_MSTART;
              end else if (filter_type == msvf_pkg::FT_NOTCH) begin
                state_nxt = S_NOTCH;
              end else begin
                state_nxt = S_DONE;
              end
            end
            msvf_pkg::OP_SHELF, msvf_pkg::OP_AP: state_nxt = S_DONE;
          endcase
        end
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (st.div_done) begin
          cmd.div_post = 1'b1;
          op_nxt       = msvf_pkg::OP_HG;
          state_nxt    = S_MSTART;
        end
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        unique case (filter_type) inside
          msvf_pkg::FT_LOW: begin
            cmd.ysel  = msvf_pkg::Y_LP;
            state_nxt = S_DONE;
          end
          msvf_pkg::FT_BAND: begin
            cmd.ysel  = msvf_pkg::Y_BP;
            state_nxt = S_DONE;
          end
          msvf_pkg::FT_HIGH: begin
            cmd.ysel  = msvf_pkg::Y_HP;
            state_nxt = S_DONE;
          end
          msvf_pkg::FT_PEAK: begin
            cmd.ysel  = msvf_pkg::Y_PEAK;
            state_nxt = S_DONE;
          end
          msvf_pkg::FT_UBAND, msvf_pkg::FT_SHELF, msvf_pkg::FT_NOTCH: begin
            op_nxt    = msvf_pkg::OP_UBP;
            state_nxt = S_MSTART;
          end
          msvf_pkg::FT_ALLPASS: begin
            op_nxt    = msvf_pkg::OP_AP;
            state_nxt = S_MSTART;
          end
        endcase
      end
      S_NOTCH: begin
        cmd.notch = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // The result register is free once its beat has been taken.
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= msvf_pkg::OP_RG;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/multimode_state_variable_filter_unit.sv =====
// ----------------------------------------------------------------------------
// multimode_state_variable_filter_unit
// Two-channel multimode state variable filter with selectable response.
// ----------------------------------------------------------------------------
// One sample is in flight at a time; a finished result waits in its own
// register, so the next sample is taken while the previous beat is still
// pending. A disabled filter goes from acceptance straight to its done state,
// where the result register is loaded. Filtering runs the restoring divider,
// which produces the 40 highpass quotient bits at one per cycle, and the
// shared multiplier for each of the five to seven products of a sample:
// five for the lowpass, bandpass, highpass and peak responses, six for unit
// bandpass, notch and allpass and seven for band shelf. A result that has
// not been taken holds the next one back in the done state.
module multimode_state_variable_filter_unit (
  input  logic        clk,
  input  logic        rst_n,
  msvf_in_if.sink     in_bus,
  msvf_out_if.source  out_bus,
  msvf_cfg_if.sink    cfg_bus
);

  logic                               en_r;
  msvf_pkg::ftype_t                   type_r;
  logic [msvf_pkg::COEF_W-1:0]        g_r;
  logic [msvf_pkg::COEF_W-1:0]        r_r;
  logic signed [msvf_pkg::COEF_W-1:0] k_r;

  msvf_pkg::cmd_t cmd;
  msvf_pkg::st_t  st;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= 1'b1;
      type_r <= msvf_pkg::FT_LOW;
      g_r    <= msvf_pkg::COEF_W'(1) << msvf_pkg::FRAC;
      r_r    <= msvf_pkg::COEF_W'(1) << msvf_pkg::FRAC;
      k_r    <= '0;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        msvf_pkg::REG_ENABLE: en_r   <= cfg_bus.data[0];
        msvf_pkg::REG_TYPE:   type_r <= cfg_bus.data[2:0];
        msvf_pkg::REG_G:      g_r    <= cfg_bus.data;
        msvf_pkg::REG_R:      r_r    <= cfg_bus.data;
        msvf_pkg::REG_K:      k_r    <= cfg_bus.data;
        default: ;
      endcase
    end
  end

  msvf_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_bus.valid),
    .in_ready    (in_bus.ready),
    .out_valid   (out_bus.valid),
    .out_ready   (out_bus.ready),
    .enable      (en_r),
    .filter_type (type_r),
    .st          (st),
    .cmd         (cmd)
  );

  msvf_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_sample     (in_bus.sample_in),
    .in_channel    (in_bus.channel),
    .in_block_end  (in_bus.block_end),
    .g_coeff       (g_r),
    .r_coeff       (r_r),
    .k_coeff       (k_r),
    .cmd           (cmd),
    .st            (st),
    .out_sample    (out_bus.sample_out),
    .out_channel   (out_bus.channel_out),
    .out_block_end (out_bus.block_end_out)
  );

  // Only one sample is worked on at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_bus.valid && in_bus.ready |=> !in_bus.ready)
    else $error("input accepted while a sample is in work");

  // Multiplier and divider are never finishing in the same cycle.
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(st.mul_done && st.div_done))
    else $error("multiplier and divider finished together");

  // A new result never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_bus.valid || out_bus.ready))
    else $error("result register overwritten before its beat was taken");

  // No result appears right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_bus.valid)
    else $error("result valid right after reset");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-channel multimode state variable filter.
// Samples go in through a queue-fed driver, results are checked in order
// against a cycle-free model of the filter kept inside the bench. The run
// steps through the reset settings, every response type, extreme and typical
// coefficients and pass-through. Both sides of the stream idle at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import msvf_pkg::*;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [CH_BITS-1:0]            channel;
    logic                          block_end;
  } sample_item_t;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [CH_BITS-1:0]            channel;
    logic                          block_end;
  } filter_result_t;

  logic clk;
  logic rst_n;

  msvf_in_if  in_bus ();
  msvf_out_if out_bus ();
  msvf_cfg_if cfg_bus ();

  multimode_state_variable_filter_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  sample_item_t   pending_samples[$];
  filter_result_t expected_results[$];

  int unsigned samples_queued   = 0;
  int unsigned samples_accepted = 0;
  int unsigned results_checked  = 0;
  int unsigned settings_used    = 0;
  int unsigned fail_count       = 0;

  bit steady_sender   = 1'b0;
  bit steady_receiver = 1'b0;
  int unsigned send_gap   = 0;
  int unsigned stall_left = 0;

  // Shadow of the filter's registers and integrators.
  bit                 filt_en;
  ftype_t             filt_type;
  logic [COEF_W-1:0]  g_coeff;
  logic [COEF_W-1:0]  r_coeff;
  logic signed [31:0] k_coeff;
  longint             integ1[NUM_CHANNELS];
  longint             integ2[NUM_CHANNELS];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    in_bus.valid      = 1'b0;
    in_bus.sample_in  = '0;
    in_bus.channel    = '0;
    in_bus.block_end  = 1'b0;
    out_bus.ready     = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = '0;
    cfg_bus.data      = '0;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic longint clamp_bits(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Signed signal times an unsigned Q8.24 magnitude, optionally negated,
  // rounded toward minus infinity.
  function automatic longint scale_q24(input longint a, input bit [63:0] m,
                                       input bit neg);
    bit        negative;
    bit [63:0] mag;
    bit [63:0] lo;
    bit [63:0] hi;
    bit [63:0] p;
    negative = (a < 0) != neg;
    mag = (a < 0) ? -a : a;
    lo = m & 64'hFF_FFFF;
    hi = m >> FRAC;
    if (negative) begin
      p = mag * hi + ((mag * lo + 64'hFF_FFFF) >> FRAC);
      return -longint'(p);
    end
    p = mag * hi + ((mag * lo) >> FRAC);
    return longint'(p);
  endfunction

  function automatic filter_result_t filter_sample(input sample_item_t it);
    filter_result_t res;
    longint    x, y, z1, z2, num, hp, bp, lp, ubp, kval;
    bit [63:0] g, r, den, nmag, quo, kmag;
    int        ch;
    x = longint'(it.sample);
    y = x;
    ch = int'(it.channel);
    if (filt_en && ch < NUM_CHANNELS) begin
      z1 = integ1[ch];
      z2 = integ2[ch];
      g = 64'(g_coeff);
      r = 64'(r_coeff);
      den = (64'd1 << FRAC) + ((r * g) >> 23) + ((g * g) >> FRAC);
      num = clamp_bits(x - scale_q24(z1, 2 * r + g, 1'b0) - z2, ST_W);
      nmag = (num < 0) ? -num : num;
      quo = (nmag << FRAC) / den;
      hp = clamp_bits((num < 0) ? -longint'(quo) : longint'(quo), ST_W);
      bp = clamp_bits(scale_q24(hp, g, 1'b0) + z1, ST_W);
      lp = clamp_bits(scale_q24(bp, g, 1'b0) + z2, ST_W);
      ubp = clamp_bits(scale_q24(bp, 2 * r, 1'b0), ST_W);
      kval = longint'(k_coeff);
      kmag = (kval < 0) ? -kval : kval;
      case (filt_type)
        FT_LOW:     y = lp;
        FT_BAND:    y = bp;
        FT_HIGH:    y = hp;
        FT_UBAND:   y = ubp;
        FT_SHELF:   y = clamp_bits(x + scale_q24(ubp, kmag, kval < 0), ST_W);
        FT_NOTCH:   y = clamp_bits(x - ubp, ST_W);
        FT_ALLPASS: y = clamp_bits(x - scale_q24(bp, 4 * r, 1'b0), ST_W);
        default:    y = clamp_bits(lp - hp, ST_W);
      endcase
      integ1[ch] = clamp_bits(scale_q24(hp, g, 1'b0) + bp, ST_W);
      integ2[ch] = clamp_bits(scale_q24(bp, g, 1'b0) + lp, ST_W);
    end
    res.sample    = SAMPLE_BITS'(clamp_bits(y, SAMPLE_BITS));
    res.channel   = it.channel;
    res.block_end = it.block_end;
    return res;
  endfunction

  function automatic int unsigned pick_pause();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  // Follows register writes and accepted samples; every accepted sample
  // is run through the shadow filter at the edge where it is taken.
  always @(posedge clk) begin : filter_shadow
    sample_item_t taken;
    if (!rst_n) begin
      filt_en   = 1'b1;
      filt_type = FT_LOW;
      g_coeff   = 32'h0100_0000;
      r_coeff   = 32'h0100_0000;
      k_coeff   = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        integ1[i] = 0;
        integ2[i] = 0;
      end
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          REG_ENABLE: filt_en   = cfg_bus.data[0];
          REG_TYPE:   filt_type = ftype_t'(cfg_bus.data[2:0]);
          REG_G:      g_coeff   = cfg_bus.data;
          REG_R:      r_coeff   = cfg_bus.data;
          REG_K:      k_coeff   = cfg_bus.data;
          default: ;
        endcase
      end
      if (in_bus.valid && in_bus.ready) begin
        taken.sample    = in_bus.sample_in;
        taken.channel   = in_bus.channel;
        taken.block_end = in_bus.block_end;
        expected_results.push_back(filter_sample(taken));
        samples_accepted++;
      end
    end
  end

  always @(posedge clk) begin : sample_driver
    sample_item_t nxt;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      send_gap = 0;
    end else if (!in_bus.valid || in_bus.ready) begin
      if (send_gap > 0) begin
        send_gap--;
        in_bus.valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        nxt = pending_samples.pop_front();
        in_bus.valid     <= 1'b1;
        in_bus.sample_in <= nxt.sample;
        in_bus.channel   <= nxt.channel;
        in_bus.block_end <= nxt.block_end;
        send_gap = steady_sender ? 0 : pick_pause();
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    filter_result_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no sample outstanding: sample_out %0d",
                 out_bus.sample_out);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (out_bus.sample_out !== want.sample) begin
            $error("sample_out: expected %0d, got %0d", want.sample, out_bus.sample_out);
            fail_count++;
          end
          if (out_bus.channel_out !== want.channel) begin
            $error("channel_out: expected %0d, got %0d", want.channel,
                   out_bus.channel_out);
            fail_count++;
          end
          if (out_bus.block_end_out !== want.block_end) begin
            $error("block_end_out: expected %0d, got %0d", want.block_end,
                   out_bus.block_end_out);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        if (!steady_receiver && $urandom_range(0, 3) == 0) stall_left = pick_pause();
      end
    end
  end

  task automatic queue_sample(input logic signed [SAMPLE_BITS-1:0] smp,
                              input logic [CH_BITS-1:0] ch, input logic last);
    sample_item_t it;
    it.sample    = smp;
    it.channel   = ch;
    it.block_end = last;
    pending_samples.push_back(it);
    samples_queued++;
  endtask

  // Called on a rising edge; returns on a rising edge with valid low again.
  task automatic write_reg(input reg_idx_t idx, input logic [COEF_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Holds off until every queued sample is taken and every result is back.
  task automatic drain();
    do @(posedge clk);
    while (samples_accepted != samples_queued || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    if (roll < 10) return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    if (roll < 35) return SAMPLE_BITS'($urandom_range(0, 4000)) - SAMPLE_BITS'(2000);
    return SAMPLE_BITS'($urandom);
  endfunction

  function automatic logic [COEF_W-1:0] pick_gain();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return '0;
    if (roll < 16) return '1;
    if (roll < 26) return $urandom;
    return $urandom_range(32'h0000_4000, 32'h0200_0000);
  endfunction

  function automatic logic [COEF_W-1:0] pick_damping();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return '0;
    if (roll < 16) return '1;
    if (roll < 26) return $urandom;
    return $urandom_range(32'h000C_CCCC, 32'h0200_0000);
  endfunction

  function automatic logic [COEF_W-1:0] pick_shelf_gain();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return 32'h8000_0000;
    if (roll < 16) return 32'h7FFF_FFFF;
    if (roll < 26) return $urandom;
    return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
  endfunction

  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  initial begin : stimulus
    bit stereo;
    wait (rst_n === 1'b1);
    @(posedge clk);

    // Register values straight out of reset.
    settings_used++;
    queue_sample(SMP_MAX, 1'b0, 1'b0);
    queue_sample(SMP_MIN, 1'b1, 1'b1);
    queue_sample('0, 1'b0, 1'b1);
    queue_sample('1, 1'b1, 1'b0);
    drain();

    // Each response with moderate coefficients, hit by both full-scale rails.
    write_reg(REG_G, 32'h0040_0000);
    write_reg(REG_R, 32'h00B5_0000);
    write_reg(REG_K, 32'h0200_0000);
    for (int t = 0; t < 8; t++) begin
      write_reg(REG_TYPE, 32'(t));
      settings_used++;
      queue_sample(SMP_MAX, 1'b0, 1'b0);
      queue_sample(SMP_MIN, 1'b1, 1'b1);
      drain();
    end

    // Largest coefficient magnitudes on the band shelf response.
    write_reg(REG_G, '1);
    write_reg(REG_R, '1);
    write_reg(REG_K, 32'h8000_0000);
    write_reg(REG_TYPE, 32'(FT_SHELF));
    settings_used++;
    queue_sample(SMP_MAX, 1'b0, 1'b0);
    queue_sample(SMP_MIN, 1'b0, 1'b1);
    drain();

    // Pass-through must leave both channels' integrators alone.
    write_reg(REG_ENABLE, 32'hFFFF_FFFE);
    write_reg(REG_K, 32'h7FFF_FFFF);
    settings_used++;
    queue_sample(SMP_MIN, 1'b1, 1'b0);
    queue_sample(SMP_MAX, 1'b0, 1'b1);
    drain();

    for (int p = 0; p < 12; p++) begin
      write_reg(REG_ENABLE, {31'($urandom_range(0, 32'h7FFF_FFFF)), (p % 5 != 4)});
      write_reg(REG_TYPE, (p < 8) ? 32'(p) : $urandom);
      write_reg(REG_G, pick_gain());
      write_reg(REG_R, pick_damping());
      write_reg(REG_K, pick_shelf_gain());
      settings_used++;
      steady_sender   = (p % 4 == 1);
      steady_receiver = (p % 4 == 1) || (p % 4 == 3);
      stereo = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 50; i++) begin
        queue_sample(random_sample(), stereo ? CH_BITS'(i) : CH_BITS'($urandom),
                     $urandom_range(0, 15) == 0);
        // Mid-phase, hold the sender back until the pipeline is empty.
        if (p == 6 && i == 24) drain();
      end
      drain();
    end
    steady_sender   = 1'b0;
    steady_receiver = 1'b0;

    repeat (100) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      fail_count++;
    end
    $display("Checked %0d results from %0d samples over %0d register settings,",
             results_checked, samples_accepted, settings_used);
    $display("covering all eight responses, pass-through and saturating coefficients.");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
